FILE: rtl/core/ordered_coordinate_keyed_table_macros.svh
// Assertion macros for the ordered coordinate-keyed table.
// Used by the top level only; needs nothing else.
`ifndef ORDERED_COORDINATE_KEYED_TABLE_MACROS_SVH
`define ORDERED_COORDINATE_KEYED_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCTAB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("octab: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OCTAB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("octab: next-cycle check failed");

`endif

FILE: rtl/core/octab_pkg.sv
// Shared types and codes for the ordered coordinate-keyed table.
// No dependencies; used by the controller, the top level and the testbench.
package octab_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Completion handed from the controller to the result register.
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } octab_done_t;

endpackage

FILE: rtl/core/ordered_coordinate_keyed_table.sv
// Top level of the ordered coordinate-keyed table: controller, entry memory, result register.
// Depends on octab_pkg, octab_entry_ram, octab_ctrl and the macros header.
//
//  Channel | Prefix | Payload                                        | Moves
//  --------+--------+------------------------------------------------+-------------------
//  input   | s_     | opcode, pos_x, pos_y, pos_z, material_word     | one request
//  result  | m_     | status, occupancy                              | one result
//
// An add or remove over a non-empty table walks the entry memory before the append; over
// an empty table it goes straight to the append. The linear search and the compaction
// shift share one walk over the entry memory, one read and one write a cycle. Clear and
// the unused opcode go straight to the report. Reset empties the table at once (the count
// is cleared; the memory is not swept). A stalled result register holds the controller in
// its reporting state, so no request is taken until it drains.
`include "ordered_coordinate_keyed_table_macros.svh"

module ordered_coordinate_keyed_table #(
    parameter int CAPACITY     = 256,
    parameter int COORD_BITS   = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_opcode,
    input  logic signed [COORD_BITS-1:0]    s_pos_x,
    input  logic signed [COORD_BITS-1:0]    s_pos_y,
    input  logic signed [COORD_BITS-1:0]    s_pos_z,
    input  logic [PAYLOAD_BITS-1:0]         s_material_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [$clog2(CAPACITY+1)-1:0]   m_occupancy
);

    localparam int KEY_BITS  = 3 * COORD_BITS;
    localparam int AW        = $clog2(CAPACITY);
    localparam int OCC_BITS  = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = KEY_BITS + PAYLOAD_BITS;

    logic [KEY_BITS-1:0]     key;
    logic                    res_free;
    octab_pkg::octab_done_t  done;
    logic [OCC_BITS-1:0]     occupancy;
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic [ENTRY_BITS-1:0]   mem_wr_data;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic [ENTRY_BITS-1:0]   mem_rd_data;

    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic [OCC_BITS-1:0]     m_occupancy_reg;

    // Key packs the three coordinates, x in the low bits.
    assign key      = {s_pos_z, s_pos_y, s_pos_x};
    assign res_free = !m_valid_reg || m_ready;

    octab_ctrl #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_key       (key),
        .s_payload   (s_material_word),
        .res_free    (res_free),
        .done        (done),
        .occupancy   (occupancy),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    octab_entry_ram #(
        .DEPTH     (CAPACITY),
        .DATA_BITS (ENTRY_BITS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Result register: loaded on completion, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done.valid) begin
            m_status_reg    <= done.status;
            m_occupancy_reg <= occupancy;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occupancy_reg;

    // The count never passes the capacity.
    `OCTAB_ASSERT_IMPL(a_count_bounded, aclk, aresetn, 1'b1, occupancy <= OCC_BITS'(CAPACITY))
    // A completion is only produced when the result register can take it.
    `OCTAB_ASSERT_IMPL(a_done_has_room, aclk, aresetn, done.valid, !m_valid_reg || m_ready)
    // In the cycle after a request is taken, the block is busy.
    `OCTAB_ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A full report always comes with a full table.
    `OCTAB_ASSERT_IMPL(a_full_at_capacity, aclk, aresetn,
        m_valid && m_status == octab_pkg::ST_FULL, m_occupancy == OCC_BITS'(CAPACITY))

endmodule

FILE: rtl/core/octab_entry_ram.sv
// Entry memory of the table: one write port, one read port, registered read data.
// Standalone; no package needed.
module octab_entry_ram #(
    parameter int DEPTH     = 256,
    parameter int DATA_BITS = 80
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: registered read data, held while the read enable is low.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/octab_ctrl.sv
// Sequencer of the table: search, compaction shift and append over the entry memory.
// Depends on octab_pkg; drives the ports of octab_entry_ram.
module octab_ctrl #(
    parameter int CAPACITY     = 256,
    parameter int KEY_BITS     = 48,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [KEY_BITS-1:0]                 s_key,
    input  logic [PAYLOAD_BITS-1:0]             s_payload,
    input  logic                                res_free,
    output octab_pkg::octab_done_t              done,
    output logic [$clog2(CAPACITY+1)-1:0]       occupancy,
    output logic                                mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
    output logic [KEY_BITS+PAYLOAD_BITS-1:0]    mem_wr_data,
    output logic                                mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
    input  logic [KEY_BITS+PAYLOAD_BITS-1:0]    mem_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_APPEND,
        S_REPORT
    } state_t;

    state_t                    state_reg,   state_next;
    logic [1:0]                op_reg,      op_next;
    logic [KEY_BITS-1:0]       key_reg,     key_next;
    logic [PAYLOAD_BITS-1:0]   pay_reg,     pay_next;
    logic [CW-1:0]             count_reg,   count_next;
    logic [CW-1:0]             rd_idx_reg,  rd_idx_next;
    logic                      chk_vld_reg, chk_vld_next;
    logic [AW-1:0]             chk_idx_reg, chk_idx_next;
    logic                      found_reg,   found_next;
    logic [1:0]                status_reg,  status_next;

    logic [CW-1:0]             count_eff;
    logic                      chk_last;
    logic                      key_hit;

    // Count after the optional removal, and walk bookkeeping.
    assign count_eff = found_reg ? (count_reg - CW'(1)) : count_reg;
    assign chk_last  = ((CW'(chk_idx_reg) + CW'(1)) == count_reg);
    assign key_hit   = (mem_rd_data[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS] == key_reg);

    assign s_ready   = (state_reg == S_IDLE);
    assign occupancy = count_reg;

    // Next-state logic and memory port control.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = rd_idx_reg[AW-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = chk_idx_reg - AW'(1);
        mem_wr_data  = mem_rd_data;
        done.valid   = 1'b0;
        done.status  = status_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_opcode;
                    key_next     = s_key;
                    pay_next     = s_payload;
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    found_next   = 1'b0;
                    status_next  = octab_pkg::ST_OK;
                    case (s_opcode)
                        octab_pkg::OP_ADD, octab_pkg::OP_REMOVE: begin
                            state_next = (count_reg == '0) ? S_APPEND : S_WALK;
                        end
                        octab_pkg::OP_CLEAR: begin
                            count_next = '0;
                            state_next = S_REPORT;
                        end
                        default: begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end

            // Read one entry a cycle; compare the entry read last cycle and,
            // once the key has been found, move each later entry down one place.
            S_WALK: begin
                if (rd_idx_reg < count_reg) begin
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[AW-1:0];
                end else begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg) begin
                    if (found_reg) begin
                        mem_wr_en = 1'b1;
                    end else if (key_hit) begin
                        found_next = 1'b1;
                    end
                    if (chk_last) begin
                        chk_vld_next = 1'b0;
                        state_next   = S_APPEND;
                    end
                end
            end

            // Settle the count and append the new entry for an add.
            S_APPEND: begin
                mem_wr_addr = count_eff[AW-1:0];
                mem_wr_data = {key_reg, pay_reg};
                count_next  = count_eff;
                if (op_reg == octab_pkg::OP_ADD) begin
                    if (count_eff == CW'(CAPACITY)) begin
                        status_next = octab_pkg::ST_FULL;
                    end else begin
                        mem_wr_en   = 1'b1;
                        count_next  = count_eff + CW'(1);
                        status_next = octab_pkg::ST_OK;
                    end
                end else begin
                    status_next = found_reg ? octab_pkg::ST_OK : octab_pkg::ST_NOT_FOUND;
                end
                state_next = S_REPORT;
            end

            // Hand the result over once the result register has room.
            S_REPORT: begin
                if (res_free) begin
                    done.valid = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            rd_idx_reg  <= '0;
            status_reg  <= octab_pkg::ST_OK;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            rd_idx_reg  <= rd_idx_next;
            status_reg  <= status_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        chk_idx_reg <= chk_idx_next;
    end

endmodule

FILE: tb/octab_tb_shadow_pkg.sv
// Shadow copy of the coordinate-keyed table and the queue of awaited outcomes.
// Depends on octab_pkg for the opcodes and status codes.
package octab_tb_shadow_pkg;

    import octab_pkg::*;

    localparam int TABLE_CAP = 256;
    localparam int OCC_BITS  = $clog2(TABLE_CAP + 1);

    // The opcode the block treats as a no-operation.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          status;
        logic [OCC_BITS-1:0] occupancy;
    } table_outcome_t;

    class entry_table_shadow;
        logic [47:0]    key_mem [TABLE_CAP];
        logic [31:0]    word_mem [TABLE_CAP];
        int unsigned    count;
        int unsigned    errors;
        table_outcome_t awaited_outcomes [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Index of the first matching key, or the count when there is none.
        function int unsigned locate(logic [47:0] key);
            for (int unsigned i = 0; i < count; i++) begin
                if (key_mem[i] == key) return i;
            end
            return count;
        endfunction

        // Drop one entry and close the gap behind it.
        function void drop_at(int unsigned idx);
            count--;
            for (int unsigned i = idx; i < count; i++) begin
                key_mem[i]  = key_mem[i + 1];
                word_mem[i] = word_mem[i + 1];
            end
        endfunction

        // Apply an accepted request and queue the outcome it should produce.
        function void log_request(logic [1:0] op, logic [47:0] key, logic [31:0] word);
            int unsigned    idx;
            table_outcome_t outcome;
            outcome.status = ST_OK;
            case (op)
                OP_ADD: begin
                    idx = locate(key);
                    if (idx < count) drop_at(idx);
                    if (count >= TABLE_CAP) begin
                        outcome.status = ST_FULL;
                    end else begin
                        key_mem[count]  = key;
                        word_mem[count] = word;
                        count++;
                    end
                end
                OP_REMOVE: begin
                    idx = locate(key);
                    if (idx < count) drop_at(idx);
                    else outcome.status = ST_NOT_FOUND;
                end
                OP_CLEAR: begin
                    count = 0;
                end
                default: begin
                end
            endcase
            outcome.occupancy = count[OCC_BITS-1:0];
            awaited_outcomes.push_back(outcome);
        endfunction

        // Compare a delivered result with the oldest awaited outcome.
        function void check_outcome(logic [1:0] status, logic [OCC_BITS-1:0] occupancy);
            table_outcome_t want;
            if (awaited_outcomes.size() == 0) begin
                $error("result with no request outstanding: status %0d, occupancy %0d",
                       status, occupancy);
                errors++;
                return;
            end
            want = awaited_outcomes.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction
    endclass

endpackage

FILE: tb/tb_ordered_coordinate_keyed_table.sv
// Testbench top for the ordered coordinate-keyed table: drives requests, checks results.
// Depends on octab_pkg, octab_tb_shadow_pkg and the ordered_coordinate_keyed_table RTL.
module tb_ordered_coordinate_keyed_table;

    import octab_pkg::*;
    import octab_tb_shadow_pkg::*;

    localparam int KEY_POOL  = 320;
    localparam int LONG_HOLD = 3000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_opcode = OP_ADD;
    logic signed [15:0]         s_pos_x = '0;
    logic signed [15:0]         s_pos_y = '0;
    logic signed [15:0]         s_pos_z = '0;
    logic [31:0]                s_material_word = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [1:0]                 m_status;
    logic [OCC_BITS-1:0]        m_occupancy;

    logic [47:0]                key_pool [KEY_POOL];
    bit                         idle_on = 1'b1;
    bit                         hold_request = 1'b0;

    entry_table_shadow shadow = new();

    ordered_coordinate_keyed_table #(
        .CAPACITY    (TABLE_CAP),
        .COORD_BITS  (16),
        .PAYLOAD_BITS(32)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_material_word(s_material_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy)
    );

    // Free-running clock.
    always #10 aclk = ~aclk;

    // Generous limit on the whole run.
    initial begin : watchdog
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [47:0] make_key(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [47:0] random_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    // Offer one request, with an occasional gap first, and wait for it to be taken.
    task automatic offer_request(logic [1:0] op, logic [47:0] key, logic [31:0] word);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_pos_x         <= key[15:0];
        s_pos_y         <= key[31:16];
        s_pos_z         <= key[47:32];
        s_material_word <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.log_request(op, key, word);
    endtask

    // Stop offering until every outstanding result has been delivered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
    endtask

    // Clear the table, fill it from a run of pool keys, overrun it, replace while full, then overrun again.
    task automatic fill_table(int start);
        offer_request(OP_CLEAR, random_key(), $urandom);
        for (int i = 0; i < TABLE_CAP + 8; i++) begin
            offer_request(OP_ADD, key_pool[(start + i) % KEY_POOL], $urandom);
        end
        repeat (6) begin
            offer_request(OP_ADD, key_pool[(start + $urandom_range(0, TABLE_CAP - 1)) % KEY_POOL],
                          $urandom);
        end
        for (int j = 0; j < 8; j++) begin
            offer_request(OP_ADD, key_pool[(start + TABLE_CAP + 8 + j) % KEY_POOL], $urandom);
        end
    endtask

    // Mixed traffic over the key pool, with some stray keys and odd opcodes.
    task automatic churn(int n);
        int          pick;
        logic [1:0]  op;
        logic [47:0] key;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            key  = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if (pick < 48) begin
                op = OP_ADD;
            end else if (pick < 83) begin
                op = OP_REMOVE;
            end else if (pick < 95) begin
                op  = (pick < 89) ? OP_ADD : OP_REMOVE;
                key = random_key();
            end else if (pick == 95) begin
                op = OP_CLEAR;
            end else begin
                op  = OP_UNUSED;
                key = random_key();
            end
            offer_request(op, key, $urandom);
        end
    endtask

    // Result side: check each delivered result and stall at random.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) shadow.check_outcome(m_status, m_occupancy);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed requests, then random phases.
    initial begin : stimulus
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = random_key();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, coordinate extremes, replacement and removal cases.
        offer_request(OP_REMOVE, make_key(16'sd0, 16'sd0, 16'sd0), 32'h0);
        offer_request(OP_ADD, make_key(16'h7fff, 16'h7fff, 16'h7fff), 32'hffff_ffff);
        offer_request(OP_ADD, make_key(16'h8000, 16'h8000, 16'h8000), 32'h0000_0000);
        offer_request(OP_ADD, make_key(16'h0000, 16'h0000, 16'h0000), 32'ha5a5_a5a5);
        offer_request(OP_ADD, make_key(16'h8000, 16'h7fff, 16'h0000), 32'h5a5a_5a5a);
        offer_request(OP_ADD, make_key(16'h7fff, 16'h7fff, 16'h7fff), 32'h1234_5678);
        offer_request(OP_REMOVE, make_key(16'h8000, 16'h8000, 16'h8000), 32'h0);
        offer_request(OP_REMOVE, make_key(16'd1, 16'd2, 16'd3), 32'h0);
        offer_request(OP_UNUSED, make_key(16'd1, 16'd2, 16'd3), 32'hdead_beef);
        offer_request(OP_ADD, make_key(16'h0001, 16'hffff, 16'h0001), 32'h0f0f_0f0f);
        offer_request(OP_REMOVE, make_key(16'h0001, 16'hffff, 16'h0001), 32'h0);
        offer_request(OP_REMOVE, make_key(16'h0000, 16'h0000, 16'h0000), 32'h0);
        offer_request(OP_CLEAR, make_key(16'h7fff, 16'h0000, 16'h8000), 32'h0);
        offer_request(OP_REMOVE, make_key(16'h7fff, 16'h7fff, 16'h7fff), 32'h0);
        offer_request(OP_CLEAR, make_key(16'h0000, 16'h0000, 16'h0000), 32'h0);
        // Keys that differ in one coordinate only must not alias.
        offer_request(OP_ADD, make_key(16'd5, 16'd5, 16'd5), 32'h0000_0001);
        offer_request(OP_ADD, make_key(16'd5, 16'd5, 16'd6), 32'h0000_0002);
        offer_request(OP_ADD, make_key(16'd5, 16'd6, 16'd5), 32'h0000_0003);
        offer_request(OP_ADD, make_key(16'd6, 16'd5, 16'd5), 32'h0000_0004);
        offer_request(OP_REMOVE, make_key(16'd5, 16'd6, 16'd5), 32'h0);
        offer_request(OP_ADD, make_key(16'd5, 16'd5, 16'd5), 32'h8000_0000);
        offer_request(OP_UNUSED, make_key(16'hffff, 16'hffff, 16'hffff), 32'hffff_ffff);

        // Random part: fill and overrun, mixed traffic with a long result stall.
        fill_table(0);
        churn(100);
        hold_request = 1'b1;
        churn(200);
        wait_drained();
        fill_table($urandom_range(0, KEY_POOL - 1));
        churn(140);

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        churn(150);

        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (shadow.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/octab_pkg.sv
rtl/core/octab_entry_ram.sv
rtl/core/octab_ctrl.sv
rtl/core/ordered_coordinate_keyed_table.sv
tb/octab_tb_shadow_pkg.sv
tb/tb_ordered_coordinate_keyed_table.sv
